// ----- rtl/core/mcrf_pkg.sv -----
// Shared types and codes for the multi-channel record FIFO.
// No dependencies; imported by mcrf_ctrl, mcrf_dp and the top level.
package mcrf_pkg;

  // Fixed field widths
  localparam int KIND_W   = 2;
  localparam int CHAN_W   = 3;
  localparam int LEN_W    = 4;
  localparam int DATA_W   = 64;
  localparam int STAT_W   = 3;
  localparam int DEP_W    = 5;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 5;
  localparam int REG_CH   = 4;

  // Request kinds
  localparam logic [KIND_W-1:0] KIND_ENQ = 2'd0;
  localparam logic [KIND_W-1:0] KIND_DEQ = 2'd1;

  // Result status codes
  localparam logic [STAT_W-1:0] ST_OK       = 3'd0;
  localparam logic [STAT_W-1:0] ST_BAD_CH   = 3'd1;
  localparam logic [STAT_W-1:0] ST_TOO_LONG = 3'd2;
  localparam logic [STAT_W-1:0] ST_FULL     = 3'd3;
  localparam logic [STAT_W-1:0] ST_EMPTY    = 3'd4;

  // Register map: depth registers from 0, record-length registers from here
  localparam logic [CFG_IDX_W-1:0] CFG_RECLEN_BASE = 3'd4;

  // Controller -> datapath
  typedef struct packed {
    logic clr_step;  // write zeros at the clear pointer and advance it
    logic load;      // capture the incoming request
    logic exec;      // execute the captured request, load the result
  } mcrf_cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic clr_last;  // clear pointer is at the last entry
    logic out_free;  // result register can take a new result this cycle
  } mcrf_stat_t;

endpackage

// ----- rtl/core/multi_channel_record_fifo.sv -----
// Top level of the multi-channel record FIFO.
// Depends on mcrf_pkg, mcrf_ctrl and mcrf_dp.
//
// Usage:
//   Up to four independent ring queues of byte records share one slot
//   memory. A request (kind, channel, length, write_data) enters on the
//   in_valid_i/in_ready_o handshake and enqueues, dequeues or queries one
//   channel (numbered from 1). Each request yields exactly one result
//   (status, read_data, full_flag, empty_flag) on out_valid_o/out_ready_i.
//   Config port: cfg_we_i writes cfg_wdata_i to register cfg_idx_i;
//   indexes 0..3 are channel depths, 4..7 record lengths. Any write
//   empties that channel (pointers only, slot contents stay). Write config
//   only while no request is in flight.
//   Sequence: an accepted request is captured, then executed once the
//   result register is free, and its result is registered. in_ready_o stays
//   low until then, so no new request is taken before the last one executes.
//   Reset: the slot memory is swept to zero, one entry per cycle, over all
//   CHANNELS*SLOTS entries (64 by default; channels above four count as
//   four) with in_ready_o low. Registers and pointers reset to zero.
//   Stall: one finished result is held in the output register while the
//   next request is accepted; that request then waits to execute until the
//   held result is taken.
module multi_channel_record_fifo #(
  parameter int CHANNELS     = 4,
  parameter int SLOTS        = 16,
  parameter int RECORD_BYTES = 8
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // configuration
  input  logic                           cfg_we_i,
  input  logic [mcrf_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [mcrf_pkg::CFG_DAT_W-1:0] cfg_wdata_i,
  // request channel
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [mcrf_pkg::KIND_W-1:0]    kind_i,
  input  logic [mcrf_pkg::CHAN_W-1:0]    channel_i,
  input  logic [mcrf_pkg::LEN_W-1:0]     length_i,
  input  logic [mcrf_pkg::DATA_W-1:0]    write_data_i,
  // result channel
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [mcrf_pkg::STAT_W-1:0]    status_o,
  output logic [mcrf_pkg::DATA_W-1:0]    read_data_o,
  output logic                           full_flag_o,
  output logic                           empty_flag_o
);
  import mcrf_pkg::*;

  mcrf_cmd_t  cmd;
  mcrf_stat_t stat;

  // sequencer: clear sweep, then accept -> execute per request
  mcrf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // registers, ring pointers, slot memory and result register
  mcrf_dp #(
    .CHANNELS     (CHANNELS),
    .SLOTS        (SLOTS),
    .RECORD_BYTES (RECORD_BYTES)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .kind_i       (kind_i),
    .channel_i    (channel_i),
    .length_i     (length_i),
    .write_data_i (write_data_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .status_o     (status_o),
    .read_data_o  (read_data_o),
    .full_flag_o  (full_flag_o),
    .empty_flag_o (empty_flag_o)
  );

endmodule

// ----- rtl/core/mcrf_ctrl.sv -----
// Sequencer for the multi-channel record FIFO: clear pass, accept, execute.
// Depends on mcrf_pkg.
module mcrf_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  mcrf_pkg::mcrf_stat_t stat_i,
  output mcrf_pkg::mcrf_cmd_t  cmd_o
);
  import mcrf_pkg::*;

  localparam logic [1:0] S_CLEAR = 2'd0;
  localparam logic [1:0] S_IDLE  = 2'd1;
  localparam logic [1:0] S_EXEC  = 2'd2;

  logic [1:0] state_q, state_d;

  always_comb begin
    state_d      = state_q;
    in_ready_o   = 1'b0;
    cmd_o        = '0;
    case (state_q)
      S_CLEAR: begin
        cmd_o.clr_step = 1'b1;
        if (stat_i.clr_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_EXEC;
        end
      end
      S_EXEC: begin
        // hold until the result register is free
        if (stat_i.out_free) begin
          cmd_o.exec = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ----- rtl/core/mcrf_dp.sv -----
// Datapath for the multi-channel record FIFO: config registers, per-channel
// pointers and counts, slot memory and result register. Depends on mcrf_pkg.
module mcrf_dp #(
  parameter int CHANNELS     = 4,
  parameter int SLOTS        = 16,
  parameter int RECORD_BYTES = 8
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  mcrf_pkg::mcrf_cmd_t               cmd_i,
  output mcrf_pkg::mcrf_stat_t              stat_o,
  input  logic                              cfg_we_i,
  input  logic [mcrf_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [mcrf_pkg::CFG_DAT_W-1:0]    cfg_wdata_i,
  input  logic [mcrf_pkg::KIND_W-1:0]       kind_i,
  input  logic [mcrf_pkg::CHAN_W-1:0]       channel_i,
  input  logic [mcrf_pkg::LEN_W-1:0]        length_i,
  input  logic [mcrf_pkg::DATA_W-1:0]       write_data_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [mcrf_pkg::STAT_W-1:0]       status_o,
  output logic [mcrf_pkg::DATA_W-1:0]       read_data_o,
  output logic                              full_flag_o,
  output logic                              empty_flag_o
);
  import mcrf_pkg::*;

  localparam int NUM_CH  = (CHANNELS < REG_CH) ? CHANNELS : REG_CH;
  localparam int CH_W    = (NUM_CH > 1) ? $clog2(NUM_CH) : 1;
  localparam int IDX_W   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int ENTRIES = NUM_CH * SLOTS;
  localparam int ADDR_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int WBITS   = RECORD_BYTES * 8;
  localparam int DEP_CAP = (SLOTS < 31) ? SLOTS : 31;
  localparam int ADV_W   = (IDX_W + 1 > DEP_W) ? IDX_W + 1 : DEP_W;

  // Config registers
  logic [DEP_W-1:0] depth_q  [REG_CH];
  logic [LEN_W-1:0] reclen_q [REG_CH];
  logic [1:0]       cfg_ch;

  assign cfg_ch = cfg_idx_i[1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < REG_CH; i++) begin
        depth_q[i]  <= '0;
        reclen_q[i] <= '0;
      end
    end else if (cfg_we_i) begin
      if (cfg_idx_i < CFG_RECLEN_BASE) begin
        depth_q[cfg_ch] <= cfg_wdata_i;
      end else begin
        reclen_q[cfg_ch] <= cfg_wdata_i[LEN_W-1:0];
      end
    end
  end

  // Captured request
  logic [KIND_W-1:0] kind_q;
  logic [CHAN_W-1:0] ch_q;
  logic [LEN_W-1:0]  len_q;
  logic [WBITS-1:0]  wdata_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      kind_q  <= kind_i;
      ch_q    <= channel_i;
      len_q   <= length_i;
      wdata_q <= write_data_i[WBITS-1:0];
    end
  end

  // Per-channel ring state
  logic [IDX_W-1:0] head_q [NUM_CH];
  logic [IDX_W-1:0] tail_q [NUM_CH];
  logic [DEP_W-1:0] cnt_q  [NUM_CH];

  // Request decode
  logic              ch_ok, is_enq, is_deq, too_long, do_enq, do_deq;
  logic [CHAN_W-1:0] ch_m1;
  logic [CH_W-1:0]   c;
  logic [1:0]        rc;
  logic [DEP_W-1:0]  dep, cnt, cnt_new;
  logic [LEN_W-1:0]  rl;
  logic [IDX_W-1:0]  head, tail, head_nxt, tail_nxt;
  logic [ADV_W-1:0]  head_inc, tail_inc;
  logic [STAT_W-1:0] status_d;
  logic [RECORD_BYTES-1:0] len_be;

  assign ch_m1 = ch_q - 3'd1;
  assign c     = ch_m1[CH_W-1:0];
  assign rc    = ch_m1[1:0];
  assign ch_ok = (ch_q != '0) && (ch_q <= CHAN_W'(NUM_CH));

  always_comb begin
    dep = (depth_q[rc] > DEP_W'(DEP_CAP)) ? DEP_W'(DEP_CAP) : depth_q[rc];
    rl  = (reclen_q[rc] > LEN_W'(RECORD_BYTES)) ? LEN_W'(RECORD_BYTES) : reclen_q[rc];
    cnt  = cnt_q[c];
    head = head_q[c];
    tail = tail_q[c];

    is_enq   = (kind_q == KIND_ENQ);
    is_deq   = (kind_q == KIND_DEQ);
    too_long = (is_enq || is_deq) && (len_q > rl);
    do_enq   = ch_ok && !too_long && is_enq && (cnt < dep);
    do_deq   = ch_ok && !too_long && is_deq && (cnt != '0) && (dep != '0);

    if (!ch_ok) begin
      status_d = ST_BAD_CH;
    end else if (too_long) begin
      status_d = ST_TOO_LONG;
    end else if (is_enq && !do_enq) begin
      status_d = ST_FULL;
    end else if (is_deq && !do_deq) begin
      status_d = ST_EMPTY;
    end else begin
      status_d = ST_OK;
    end

    cnt_new = cnt;
    if (do_enq) begin
      cnt_new = cnt + 1'b1;
    end else if (do_deq) begin
      cnt_new = cnt - 1'b1;
    end

    // ring advance wraps at the effective depth
    head_inc = ADV_W'(head) + 1'b1;
    tail_inc = ADV_W'(tail) + 1'b1;
    head_nxt = (head_inc >= ADV_W'(dep)) ? '0 : head_inc[IDX_W-1:0];
    tail_nxt = (tail_inc >= ADV_W'(dep)) ? '0 : tail_inc[IDX_W-1:0];

    for (int b = 0; b < RECORD_BYTES; b++) begin
      len_be[b] = (LEN_W'(b) < len_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_CH; i++) begin
        head_q[i] <= '0;
        tail_q[i] <= '0;
        cnt_q[i]  <= '0;
      end
    end else begin
      for (int i = 0; i < NUM_CH; i++) begin
        if (cfg_we_i && (cfg_ch == 2'(i))) begin
          head_q[i] <= '0;
          tail_q[i] <= '0;
          cnt_q[i]  <= '0;
        end else if (cmd_i.exec && ch_ok && (c == CH_W'(i))) begin
          if (do_enq) begin
            tail_q[i] <= tail_nxt;
          end
          if (do_deq) begin
            head_q[i] <= head_nxt;
          end
          cnt_q[i] <= cnt_new;
        end
      end
    end
  end

  // Slot memory with byte write enables; cleared by a sweep after reset
  logic [WBITS-1:0]        mem [ENTRIES];
  logic [WBITS-1:0]        rd_q;
  logic [ADDR_W-1:0]       clr_q, slot_base, waddr, raddr;
  logic                    mem_we, mem_re;
  logic [RECORD_BYTES-1:0] mem_be;
  logic [WBITS-1:0]        mem_wd;

  assign slot_base = ADDR_W'(c) * ADDR_W'(SLOTS);
  assign raddr     = slot_base + ADDR_W'(head);

  always_comb begin
    if (cmd_i.clr_step) begin
      mem_we = 1'b1;
      mem_be = '1;
      mem_wd = '0;
      waddr  = clr_q;
    end else begin
      mem_we = cmd_i.exec && do_enq;
      mem_be = len_be;
      mem_wd = wdata_q;
      waddr  = slot_base + ADDR_W'(tail);
    end
    mem_re = cmd_i.exec && do_deq;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      for (int b = 0; b < RECORD_BYTES; b++) begin
        if (mem_be[b]) begin
          mem[waddr][b*8 +: 8] <= mem_wd[b*8 +: 8];
        end
      end
    end
    if (mem_re) begin
      rd_q <= mem[raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (cmd_i.clr_step) begin
      clr_q <= clr_q + 1'b1;
    end
  end

  assign stat_o.clr_last = (clr_q == ADDR_W'(ENTRIES - 1));

  // Result register
  logic                    out_valid_q;
  logic [STAT_W-1:0]       status_q;
  logic                    full_q, empty_q;
  logic [RECORD_BYTES-1:0] rbe_q;
  logic [WBITS-1:0]        rd_masked;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.exec) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      status_q <= status_d;
      full_q   <= ch_ok && (cnt_new == dep);
      empty_q  <= ch_ok && (cnt_new == '0);
      rbe_q    <= do_deq ? len_be : '0;
    end
  end

  always_comb begin
    for (int b = 0; b < RECORD_BYTES; b++) begin
      rd_masked[b*8 +: 8] = rbe_q[b] ? rd_q[b*8 +: 8] : 8'h00;
    end
  end

  assign stat_o.out_free = !out_valid_q || out_ready_i;
  assign out_valid_o     = out_valid_q;
  assign status_o        = status_q;
  assign full_flag_o     = full_q;
  assign empty_flag_o    = empty_q;
  assign read_data_o     = DATA_W'(rd_masked);

endmodule

// ----- tb/sv/tb_multi_channel_record_fifo.sv -----
// Self-checking testbench for multi_channel_record_fifo: directed and random
// requests, per-channel queue predictor in a small scoreboard class.
// Depends on mcrf_pkg and the multi_channel_record_fifo RTL only.
module tb_multi_channel_record_fifo;
  timeunit 1ns;
  timeprecision 1ps;

  import mcrf_pkg::*;

  localparam int unsigned NUM_CH          = 4;
  localparam int unsigned SLOTS_PER_CH    = 16;
  localparam int unsigned MAX_REC_BYTES   = 8;
  localparam int unsigned ITEMS_PER_PHASE = 100;
  // Cycles with no request or result moving before the run is declared hung.
  // Covers the memory sweep after reset and long random stall streaks.
  localparam int unsigned QUIET_LIMIT     = 1000;

  // Request kinds the package leaves unnamed; the spare code acts as a query.
  localparam logic [KIND_W-1:0] KIND_QUERY = 2'd2;
  localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;

  // Depth registers start at index 0, record lengths at CFG_RECLEN_BASE.
  localparam logic [CFG_IDX_W-1:0] CFG_DEPTH_BASE = 3'd0;

  typedef struct {
    logic [KIND_W-1:0] kind;
    logic [CHAN_W-1:0] chan;
    logic [LEN_W-1:0]  len;
    logic [DATA_W-1:0] data;
  } fifo_req_t;

  typedef struct {
    logic [STAT_W-1:0] status;
    logic [DATA_W-1:0] rdata;
    logic              full;
    logic              empty;
  } fifo_result_t;

  // Shadow copy of the queues: registers, slot memory, pointers and counts.
  // note_request() computes the result a request must produce and queues it;
  // check_result() compares what came out against the oldest one.
  class record_fifo_scoreboard;
    bit [DEP_W-1:0]  depth_reg[NUM_CH];
    bit [LEN_W-1:0]  reclen_reg[NUM_CH];
    bit [DATA_W-1:0] slot_mem[NUM_CH*SLOTS_PER_CH];
    int unsigned     head_ptr[NUM_CH];
    int unsigned     tail_ptr[NUM_CH];
    int unsigned     fill[NUM_CH];
    fifo_result_t    pending_results[$];
    int unsigned     mismatches;

    function int unsigned eff_depth(int unsigned c);
      return (depth_reg[c] > SLOTS_PER_CH) ? SLOTS_PER_CH : depth_reg[c];
    endfunction

    function int unsigned eff_reclen(int unsigned c);
      return (reclen_reg[c] > MAX_REC_BYTES) ? MAX_REC_BYTES : reclen_reg[c];
    endfunction

    function bit [DATA_W-1:0] byte_mask(int unsigned n);
      if (n >= MAX_REC_BYTES) return {DATA_W{1'b1}};
      return (64'd1 << (8 * n)) - 64'd1;
    endfunction

    function int unsigned next_ptr(int unsigned ptr, int unsigned depth);
      return (ptr + 1 >= depth) ? 0 : ptr + 1;
    endfunction

    // Any register write empties its channel; slot contents are kept.
    function void apply_reg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] val);
      int unsigned c;
      if (idx < CFG_RECLEN_BASE) begin
        c = 32'(idx - CFG_DEPTH_BASE);
        depth_reg[c] = val;
      end else begin
        c = 32'(idx - CFG_RECLEN_BASE);
        reclen_reg[c] = val[LEN_W-1:0];
      end
      head_ptr[c] = 0;
      tail_ptr[c] = 0;
      fill[c]     = 0;
    endfunction

    function void note_request(fifo_req_t r);
      fifo_result_t res;
      int unsigned  c;
      int unsigned  depth;
      int unsigned  s;
      bit [DATA_W-1:0] m;
      res.status = ST_OK;
      res.rdata  = '0;
      res.full   = 1'b0;
      res.empty  = 1'b0;
      if (r.chan == 0 || r.chan > NUM_CH) begin
        res.status = ST_BAD_CH;
        pending_results.push_back(res);
        return;
      end
      c     = r.chan - 1;
      depth = eff_depth(c);
      m     = byte_mask(32'(r.len));
      // length check first, then full/empty; queries skip both
      if ((r.kind == KIND_ENQ || r.kind == KIND_DEQ) && r.len > eff_reclen(c)) begin
        res.status = ST_TOO_LONG;
      end else if (r.kind == KIND_ENQ) begin
        if (fill[c] >= depth) begin
          res.status = ST_FULL;
        end else begin
          // only the low len bytes of the slot are replaced
          s = c * SLOTS_PER_CH + tail_ptr[c];
          slot_mem[s] = (slot_mem[s] & ~m) | (r.data & m);
          tail_ptr[c] = next_ptr(tail_ptr[c], depth);
          fill[c]++;
        end
      end else if (r.kind == KIND_DEQ) begin
        if (fill[c] == 0 || depth == 0) begin
          res.status = ST_EMPTY;
        end else begin
          s = c * SLOTS_PER_CH + head_ptr[c];
          res.rdata   = slot_mem[s] & m;
          head_ptr[c] = next_ptr(head_ptr[c], depth);
          fill[c]--;
        end
      end
      res.full  = (fill[c] == depth);
      res.empty = (fill[c] == 0);
      pending_results.push_back(res);
    endfunction

    function void check_result(fifo_result_t got);
      fifo_result_t exp_res;
      if (pending_results.size() == 0) begin
        mismatches++;
        $display("%0t: result with none outstanding: status=%0d read_data=%h",
                 $time, got.status, got.rdata);
        return;
      end
      exp_res = pending_results.pop_front();
      if (got.status !== exp_res.status) begin
        mismatches++;
        $display("%0t: status expected %0d, got %0d", $time, exp_res.status, got.status);
      end
      if (got.rdata !== exp_res.rdata) begin
        mismatches++;
        $display("%0t: read_data expected %h, got %h", $time, exp_res.rdata, got.rdata);
      end
      if (got.full !== exp_res.full) begin
        mismatches++;
        $display("%0t: full_flag expected %0b, got %0b", $time, exp_res.full, got.full);
      end
      if (got.empty !== exp_res.empty) begin
        mismatches++;
        $display("%0t: empty_flag expected %0b, got %0b", $time, exp_res.empty, got.empty);
      end
    endfunction
  endclass

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_DAT_W-1:0] cfg_wdata_i;
  logic                 in_valid_i;
  logic                 in_ready_o;
  logic [KIND_W-1:0]    kind_i;
  logic [CHAN_W-1:0]    channel_i;
  logic [LEN_W-1:0]     length_i;
  logic [DATA_W-1:0]    write_data_i;
  logic                 out_valid_o;
  logic                 out_ready_i;
  logic [STAT_W-1:0]    status_o;
  logic [DATA_W-1:0]    read_data_o;
  logic                 full_flag_o;
  logic                 empty_flag_o;

  record_fifo_scoreboard sb;
  fifo_result_t          seen_result;
  int unsigned           send_idle_pct;   // chance per cycle the sender holds off
  int unsigned           recv_stall_pct;  // chance per cycle out_ready_i is low
  int unsigned           quiet_cycles;

  multi_channel_record_fifo DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .kind_i       (kind_i),
    .channel_i    (channel_i),
    .length_i     (length_i),
    .write_data_i (write_data_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .status_o     (status_o),
    .read_data_o  (read_data_o),
    .full_flag_o  (full_flag_o),
    .empty_flag_o (empty_flag_o)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Result side: sample the handshake with pre-edge values, then pick the
  // next cycle's ready at random.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o === 1'b1 && out_ready_i) begin
      seen_result.status = status_o;
      seen_result.rdata  = read_data_o;
      seen_result.full   = full_flag_o;
      seen_result.empty  = empty_flag_o;
      sb.check_result(seen_result);
    end
    out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Hang detection: nothing moved on either side for too long.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o === 1'b1) || (out_valid_o === 1'b1 && out_ready_i))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Present one request and hold it until accepted. Valid is only dropped
  // when the sender decides to idle, so back-to-back requests never see a
  // low/high pair of assignments in the same step.
  task automatic send_request(input fifo_req_t r);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid_i   <= 1'b1;
    kind_i       <= r.kind;
    channel_i    <= r.chan;
    length_i     <= r.len;
    write_data_i <= r.data;
    do @(posedge clk_i); while (in_ready_o !== 1'b1);
    sb.note_request(r);
  endtask

  task automatic issue(input logic [KIND_W-1:0] kind, input logic [CHAN_W-1:0] chan,
                       input logic [LEN_W-1:0] len, input logic [DATA_W-1:0] data);
    fifo_req_t r;
    r.kind = kind;
    r.chan = chan;
    r.len  = len;
    r.data = data;
    send_request(r);
  endtask

  // Mostly well-formed requests on live channels with legal lengths; the
  // rest hit bad channels and over-long lengths.
  task automatic issue_random();
    fifo_req_t   r;
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 47)      r.kind = KIND_ENQ;
    else if (pick < 90) r.kind = KIND_DEQ;
    else if (pick < 95) r.kind = KIND_QUERY;
    else                r.kind = KIND_SPARE;
    // 8 wraps to 0 in the 3-bit field, so this draws from {5,6,7,0}
    if ($urandom_range(99) < 8) r.chan = CHAN_W'($urandom_range(NUM_CH + 1, 8));
    else                        r.chan = CHAN_W'($urandom_range(1, NUM_CH));
    if (r.chan != 0 && r.chan <= NUM_CH && $urandom_range(9) != 0)
      r.len = LEN_W'($urandom_range(sb.eff_reclen(r.chan - 1)));
    else
      r.len = LEN_W'($urandom_range(15));
    r.data = {$urandom, $urandom};
    send_request(r);
  endtask

  // Stop sending and let every outstanding result come back; the block is
  // then idle and safe to reconfigure.
  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Write all eight registers back to back, depths first.
  task automatic program_regs(input bit [CFG_DAT_W-1:0] depths[NUM_CH],
                              input bit [CFG_DAT_W-1:0] lens[NUM_CH]);
    drain_results();
    cfg_we_i <= 1'b1;
    for (int i = 0; i < NUM_CH; i++) begin
      cfg_idx_i   <= CFG_IDX_W'(CFG_DEPTH_BASE + i);
      cfg_wdata_i <= depths[i];
      @(posedge clk_i);
      sb.apply_reg_write(CFG_IDX_W'(CFG_DEPTH_BASE + i), depths[i]);
    end
    for (int i = 0; i < NUM_CH; i++) begin
      cfg_idx_i   <= CFG_IDX_W'(CFG_RECLEN_BASE + i);
      cfg_wdata_i <= lens[i];
      @(posedge clk_i);
      sb.apply_reg_write(CFG_IDX_W'(CFG_RECLEN_BASE + i), lens[i]);
    end
    cfg_we_i <= 1'b0;
  endtask

  initial begin
    bit [CFG_DAT_W-1:0] depths[NUM_CH];
    bit [CFG_DAT_W-1:0] lens[NUM_CH];
    sb             = new;
    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_idx_i      = '0;
    cfg_wdata_i    = '0;
    in_valid_i     = 1'b0;
    kind_i         = KIND_ENQ;
    channel_i      = '0;
    length_i       = '0;
    write_data_i   = '0;
    out_ready_i    = 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    quiet_cycles   = 0;

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    // in_ready_o stays low while the slot memory is swept after reset
    do @(posedge clk_i); while (in_ready_o !== 1'b1);

    // ---- directed part, no idling ----
    // ch1: depth 4, full-size records; ch2: 16 slots of 3 bytes;
    // ch3: oversized registers (act as 16 and 8); ch4: disabled.
    depths = '{5'd4, 5'd16, 5'd31, 5'd0};
    lens   = '{5'd8, 5'd3, 5'd15, 5'd0};
    program_regs(depths, lens);

    // bad channels: zero and above four, some with nonzero length and data
    issue(KIND_ENQ,   3'd0, 4'd0,  64'hFFFF_FFFF_FFFF_FFFF);
    issue(KIND_DEQ,   3'd7, 4'd15, 64'hFFFF_FFFF_FFFF_FFFF);
    issue(KIND_QUERY, 3'd5, 4'd0,  64'h0);
    // disabled channel reports full on enqueue, empty on dequeue, too long for length 1
    issue(KIND_ENQ,   3'd4, 4'd0,  64'hFFFF_FFFF_FFFF_FFFF);
    issue(KIND_DEQ,   3'd4, 4'd0,  64'h0);
    issue(KIND_ENQ,   3'd4, 4'd1,  64'h0);
    // ch1: dequeue while empty, fill to full, over-long lengths, queries
    issue(KIND_DEQ,   3'd1, 4'd8,  64'h0);
    issue(KIND_ENQ,   3'd1, 4'd8,  64'hFFFF_FFFF_FFFF_FFFF);
    issue(KIND_ENQ,   3'd1, 4'd0,  64'h0123_4567_89AB_CDEF);
    issue(KIND_ENQ,   3'd1, 4'd3,  64'hAAAA_AAAA_AAAA_AAAA);
    issue(KIND_ENQ,   3'd1, 4'd15, 64'h1111_1111_1111_1111);
    issue(KIND_ENQ,   3'd1, 4'd8,  64'h5555_5555_5555_5555);
    issue(KIND_ENQ,   3'd1, 4'd8,  64'h0);
    issue(KIND_QUERY, 3'd1, 4'd15, 64'hFFFF_FFFF_FFFF_FFFF);
    issue(KIND_SPARE, 3'd1, 4'd0,  64'h0);
    issue(KIND_DEQ,   3'd1, 4'd9,  64'h0);
    // drain with mixed lengths: upper bytes must come back zero
    issue(KIND_DEQ,   3'd1, 4'd8,  64'h0);
    issue(KIND_DEQ,   3'd1, 4'd2,  64'h0);
    issue(KIND_DEQ,   3'd1, 4'd8,  64'h0);
    issue(KIND_DEQ,   3'd1, 4'd5,  64'h0);
    issue(KIND_DEQ,   3'd1, 4'd0,  64'h0);
    // pointers wrapped to slot 0: a short write keeps the old upper bytes
    issue(KIND_ENQ,   3'd1, 4'd2,  64'h0000_0000_0000_1234);
    issue(KIND_DEQ,   3'd1, 4'd8,  64'h0);
    // clamped ch3 and short-record ch2
    issue(KIND_ENQ,   3'd3, 4'd8,  64'hFEDC_BA98_7654_3210);
    issue(KIND_ENQ,   3'd2, 4'd4,  64'h0);
    issue(KIND_ENQ,   3'd2, 4'd3,  64'h00C0_FFEE_00BE_EF01);
    issue(KIND_DEQ,   3'd2, 4'd3,  64'h0);

    // ---- random part, one idling pattern per phase ----
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 85; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 85; end
        default: begin send_idle_pct = 11; recv_stall_pct = 11; end
      endcase
      // small depths dominate so queues fill and empty often; extremes
      // and oversized values show up now and then
      for (int c = 0; c < NUM_CH; c++) begin
        case ($urandom_range(9))
          0: depths[c] = 5'd0;
          1: depths[c] = 5'd31;
          2: depths[c] = 5'd16;
          3: depths[c] = CFG_DAT_W'($urandom_range(17, 30));
          default: depths[c] = CFG_DAT_W'($urandom_range(1, 6));
        endcase
        if ($urandom_range(3) == 0) lens[c] = CFG_DAT_W'($urandom_range(31));
        else                        lens[c] = CFG_DAT_W'($urandom_range(1, 8));
      end
      program_regs(depths, lens);
      repeat (ITEMS_PER_PHASE) issue_random();
    end

    // wait for the last results, plus a few cycles to catch strays
    drain_results();
    repeat (8) @(posedge clk_i);
    if (sb.mismatches == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
